### rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define HSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond is never true outside reset.
`define HSV_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/hsv2rgb_pkg.sv
// Types and constants for the HSV to RGB converter pipeline.
// No dependencies; used by every module of the converter.
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_W      = 15;
  localparam int CH_W       = 8;
  localparam int FRAC_W     = 12;
  localparam int PROD_W     = 20;
  localparam int WIDE_W     = 28;
  localparam int PNUM_W     = 16;

  localparam int SECTOR_SPAN   = 3840;
  localparam int FULL_SCALE    = 255;
  localparam int SCALE_PRODUCT = FULL_SCALE * SECTOR_SPAN;
  localparam int MAX_SECTOR    = ((2 ** HUE_W) - 1) / SECTOR_SPAN;

  // floor(x / 255) for x < 2^16: (x * P_RECIP) >> 24
  localparam logic [16:0] P_RECIP = 17'd65794;
  localparam int          P_SHIFT = 24;
  // floor(x / 979200) = floor((x >> 8) / 3825); (y * Q_RECIP) >> 32 for y < 2^20
  localparam int          Q_PRESHIFT = 8;
  localparam logic [20:0] Q_RECIP    = 21'd1122868;
  localparam int          Q_SHIFT    = 32;

  typedef enum logic [3:0] {
    SECT_0 = 4'd0,
    SECT_1 = 4'd1,
    SECT_2 = 4'd2,
    SECT_3 = 4'd3,
    SECT_4 = 4'd4,
    SECT_5 = 4'd5,
    SECT_6 = 4'd6,
    SECT_7 = 4'd7,
    SECT_8 = 4'd8
  } sector_t;

  typedef struct packed {
    sector_t             sector;
    logic [FRAC_W-1:0]   frac;
    logic [CH_W-1:0]     sat;
    logic [CH_W-1:0]     val;
  } s1_t;

  typedef struct packed {
    sector_t             sector;
    logic [PROD_W-1:0]   keep_q;
    logic [PROD_W-1:0]   keep_t;
    logic [CH_W-1:0]     p;
    logic [CH_W-1:0]     val;
  } s3_t;

  typedef struct packed {
    sector_t             sector;
    logic [CH_W-1:0]     q;
    logic [CH_W-1:0]     t;
    logic [CH_W-1:0]     p;
    logic [CH_W-1:0]     val;
  } s5_t;

endpackage

`default_nettype wire

### rtl/hsv2rgb_sector.sv
// Stage 1: split the hue into sector and fraction over one 60 degree span.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [HUE_W-1:0]  in_hue,
  input  wire logic [CH_W-1:0]   in_sat,
  input  wire logic [CH_W-1:0]   in_val,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output s1_t                    out_data
);

  logic       v_r;
  s1_t        d_r;
  s1_t        d_nxt;
  logic [3:0] sec_idx;
  logic [HUE_W-1:0] base;
  logic       rdy;

  always_comb begin
    sec_idx = '0;
    base    = '0;
    for (int k = 1; k <= MAX_SECTOR; k++) begin
      if (in_hue >= HUE_W'(k * SECTOR_SPAN)) begin
        sec_idx = 4'(k);
        base    = HUE_W'(k * SECTOR_SPAN);
      end
    end
    d_nxt.sector = sector_t'(sec_idx);
    d_nxt.frac   = FRAC_W'(in_hue - base);
    d_nxt.sat    = in_sat;
    d_nxt.val    = in_val;
  end

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

`include "assert_macros.svh"

  `HSV_ASSERT(a_frac_in_span, v_r |-> (d_r.frac < FRAC_W'(SECTOR_SPAN)), "fraction out of span")

endmodule

`default_nettype wire

### rtl/hsv2rgb_mult.sv
// Stages 2 and 3: saturation products, keep factors and the p channel.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mult
  import hsv2rgb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  s1_t        in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output s3_t        out_data
);

  typedef struct packed {
    sector_t           sector;
    logic [PROD_W-1:0] mq;
    logic [PROD_W-1:0] mt;
    logic [PNUM_W-1:0] w;
    logic [CH_W-1:0]   val;
  } s2_t;

  logic              v2_r;
  logic              v3_r;
  s2_t               d2_r;
  s2_t               d2_nxt;
  s3_t               d3_r;
  s3_t               d3_nxt;
  logic [FRAC_W-1:0] rfrac;
  logic [PNUM_W+16:0] pprod;
  logic              rdy2;
  logic              rdy3;

  always_comb begin
    rfrac         = FRAC_W'(SECTOR_SPAN) - in_data.frac;
    d2_nxt.sector = in_data.sector;
    d2_nxt.mq     = PROD_W'(in_data.sat) * PROD_W'(in_data.frac);
    d2_nxt.mt     = PROD_W'(in_data.sat) * PROD_W'(rfrac);
    d2_nxt.w      = PNUM_W'(in_data.val) * PNUM_W'(CH_W'(FULL_SCALE) - in_data.sat);
    d2_nxt.val    = in_data.val;
  end

  always_comb begin
    pprod         = (PNUM_W+17)'(d2_r.w) * (PNUM_W+17)'(P_RECIP);
    d3_nxt.sector = d2_r.sector;
    d3_nxt.keep_q = PROD_W'(SCALE_PRODUCT) - d2_r.mq;
    d3_nxt.keep_t = PROD_W'(SCALE_PRODUCT) - d2_r.mt;
    d3_nxt.p      = pprod[P_SHIFT+CH_W-1:P_SHIFT];
    d3_nxt.val    = d2_r.val;
  end

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= in_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      d2_r <= d2_nxt;
    end
    if (rdy3 && v2_r) begin
      d3_r <= d3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

`include "assert_macros.svh"

  `HSV_ASSERT(a_p_le_val, v3_r |-> (d3_r.p <= d3_r.val), "p channel exceeds value")

endmodule

`default_nettype wire

### rtl/hsv2rgb_scale.sv
// Stages 4 and 5: scale the keep factors by value and divide by 255*3840.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  s3_t        in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output s5_t        out_data
);

  localparam int Y_W = WIDE_W - Q_PRESHIFT;
  localparam int QP_W = Y_W + 21;

  typedef struct packed {
    sector_t           sector;
    logic [WIDE_W-1:0] xq;
    logic [WIDE_W-1:0] xt;
    logic [CH_W-1:0]   p;
    logic [CH_W-1:0]   val;
  } s4_t;

  logic            v4_r;
  logic            v5_r;
  s4_t             d4_r;
  s4_t             d4_nxt;
  s5_t             d5_r;
  s5_t             d5_nxt;
  logic [QP_W-1:0] qprod;
  logic [QP_W-1:0] tprod;
  logic            rdy4;
  logic            rdy5;

  always_comb begin
    d4_nxt.sector = in_data.sector;
    d4_nxt.xq     = WIDE_W'(in_data.val) * WIDE_W'(in_data.keep_q);
    d4_nxt.xt     = WIDE_W'(in_data.val) * WIDE_W'(in_data.keep_t);
    d4_nxt.p      = in_data.p;
    d4_nxt.val    = in_data.val;
  end

  always_comb begin
    qprod         = QP_W'(d4_r.xq[WIDE_W-1:Q_PRESHIFT]) * QP_W'(Q_RECIP);
    tprod         = QP_W'(d4_r.xt[WIDE_W-1:Q_PRESHIFT]) * QP_W'(Q_RECIP);
    d5_nxt.sector = d4_r.sector;
    d5_nxt.q      = qprod[Q_SHIFT+CH_W-1:Q_SHIFT];
    d5_nxt.t      = tprod[Q_SHIFT+CH_W-1:Q_SHIFT];
    d5_nxt.p      = d4_r.p;
    d5_nxt.val    = d4_r.val;
  end

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= in_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && in_valid) begin
      d4_r <= d4_nxt;
    end
    if (rdy5 && v4_r) begin
      d5_r <= d5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = d5_r;

`include "assert_macros.svh"

  `HSV_ASSERT(a_q_le_val, v5_r |-> (d5_r.q <= d5_r.val), "q channel exceeds value")
  `HSV_ASSERT(a_t_le_val, v5_r |-> (d5_r.t <= d5_r.val), "t channel exceeds value")

endmodule

`default_nettype wire

### rtl/hsv2rgb_mux.sv
// Stage 6: sector mux into the output register.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mux
  import hsv2rgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  s5_t              in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  logic            v_r;
  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] green_r;
  logic [CH_W-1:0] blue_r;
  logic [CH_W-1:0] red_nxt;
  logic [CH_W-1:0] green_nxt;
  logic [CH_W-1:0] blue_nxt;
  logic            rdy;

  always_comb begin
    unique case (in_data.sector)
      SECT_1: begin
        red_nxt = in_data.q; green_nxt = in_data.val; blue_nxt = in_data.p;
      end
      SECT_2: begin
        red_nxt = in_data.p; green_nxt = in_data.val; blue_nxt = in_data.t;
      end
      SECT_3: begin
        red_nxt = in_data.p; green_nxt = in_data.q; blue_nxt = in_data.val;
      end
      SECT_4: begin
        red_nxt = in_data.t; green_nxt = in_data.p; blue_nxt = in_data.val;
      end
      SECT_5: begin
        red_nxt = in_data.val; green_nxt = in_data.p; blue_nxt = in_data.q;
      end
      default: begin
        red_nxt = in_data.val; green_nxt = in_data.t; blue_nxt = in_data.p;
      end
    endcase
  end

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level: six-stage pipeline of the stage modules.
// Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_mult, hsv2rgb_scale, hsv2rgb_mux.
//
// Usage:
//   Input channel in_valid/in_ready carries one HSV pixel per item: in_hue
//   (degrees, 6 fraction bits), in_sat and in_val (255 = 1.0).
//   Output channel out_valid/out_ready carries one RGB pixel per item:
//   out_red, out_green, out_blue, truncated 8-bit.
//   Path: an accepted item passes the registers of stages 1 to 6 in order;
//   out_valid rises once the stage 6 output register holds it.
//   Throughput: one item per cycle while out_ready is high; each stage holds
//   one item, and the stage 2 to 5 multipliers take a new operand each cycle.
//   Stalls: every stage has its own valid bit and takes a new item when it
//   is empty or its successor takes its item, so empty stages fill up while
//   out_ready is low; in_ready drops only once all six stages hold items.
//   Items are never dropped or repeated across a stall.
//   Reset: rst_n low at a rising edge empties the pipeline; in_ready is
//   high in the first cycle after reset.
`default_nettype none

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [HUE_W-1:0]  in_hue,
  input  wire logic [CH_W-1:0]   in_sat,
  input  wire logic [CH_W-1:0]   in_val,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CH_W-1:0]        out_red,
  output logic [CH_W-1:0]        out_green,
  output logic [CH_W-1:0]        out_blue
);

  s1_t  s1_data;
  s3_t  s3_data;
  s5_t  s5_data;
  logic s1_valid;
  logic s1_ready;
  logic s3_valid;
  logic s3_ready;
  logic s5_valid;
  logic s5_ready;

  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_hue    (in_hue),
    .in_sat    (in_sat),
    .in_val    (in_val),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  hsv2rgb_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (s5_valid),
    .out_ready (s5_ready),
    .out_data  (s5_data)
  );

  hsv2rgb_mux u_mux (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s5_valid),
    .in_ready  (s5_ready),
    .in_data   (s5_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

`default_nettype wire
